// ===== design/psd_pkg.sv =====
`timescale 1ns / 1ps

package psd_pkg;

    // Shared divider geometry
    localparam int DIV_DW = 48;
    localparam int DIV_SW = 32;
    localparam int DIV_CW = 6;
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_DW - 1);

    localparam int SYM_W   = 9;
    localparam int WHOLE_W = 30;
    localparam int FRAC_W  = 15;
    localparam int SC_W    = 23;
    localparam int ACC_W   = 53;

    // Bit 8 set marks the end of the text
    localparam logic [SYM_W-1:0] SYM_END = 9'h100;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [SC_W-1:0]    INCH_SP     = 23'd4736286;
    localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 30'd100000000;
    localparam logic [ACC_W-1:0]   SCALED_MAX  = 53'h4000_0000;

    localparam logic [1:0] CFG_DPI    = 2'd0;
    localparam logic [1:0] CFG_SHRINK = 2'd1;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quot;
        logic [DIV_SW-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic            hit;
        logic [SC_W-1:0] sc;
    } t_unit_hit;

    // Scaled points per unit for the two-letter unit names
    function automatic t_unit_hit unit_lookup(input logic [7:0] c1, input logic [7:0] c2);
        t_unit_hit u;
        u.hit = 1'b1;
        u.sc  = INCH_SP;
        unique case ({c1, c2})
            "cm":    u.sc = 23'd1864680;
            "pt":    u.sc = 23'd65536;
            "pc":    u.sc = 23'd786432;
            "mm":    u.sc = 23'd186468;
            "sp":    u.sc = 23'd1;
            "bp":    u.sc = 23'd65782;
            "dd":    u.sc = 23'd70124;
            "cc":    u.sc = 23'd841489;
            "in":    u.sc = INCH_SP;
            default: u.hit = 1'b0;
        endcase
        return u;
    endfunction

endpackage

// ===== design/psd_div.sv =====
`timescale 1ns / 1ps

module psd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psd_pkg::t_div_req  i_req,
    output psd_pkg::t_div_rsp  o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [psd_pkg::DIV_CW-1:0]   r_cnt;
    logic [psd_pkg::DIV_DW-1:0]   r_dvd;
    logic [psd_pkg::DIV_SW-1:0]   r_rem;
    logic [psd_pkg::DIV_SW-1:0]   r_dsr;
    logic [psd_pkg::DIV_SW:0]     rem_sh;
    logic [psd_pkg::DIV_SW:0]     diff;
    logic                         ge;

    always_comb begin
        rem_sh = {r_rem, r_dvd[psd_pkg::DIV_DW-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        ge     = rem_sh >= {1'b0, r_dsr};
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? diff[psd_pkg::DIV_SW-1:0] : rem_sh[psd_pkg::DIV_SW-1:0];
                r_dvd <= {r_dvd[psd_pkg::DIV_DW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psd_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== design/paper_size_string_to_dots_unit.sv =====
`timescale 1ns / 1ps
// A character is registered, then passes through one to six parse steps; closing a
// dimension takes three shared-divider passes and five multiplies.
// Throughput: one character at a time, input not ready until it is used up; the result
// waits in an output register while the next text is taken.
// Reset (synchronous, active low) clears the parser and output valid, and sets
// dots_per_inch to 300 and shrink_factor to 1.
module paper_size_string_to_dots_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_width_dots,
    output logic signed [31:0] o_height_dots,
    output logic        o_overflow,
    output logic        o_defaults_used,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_STEP = 4'd1;
    localparam logic [3:0] ST_EMIT = 4'd2;
    localparam logic [3:0] ST_D1S  = 4'd3;
    localparam logic [3:0] ST_D1W  = 4'd4;
    localparam logic [3:0] ST_M1   = 4'd5;
    localparam logic [3:0] ST_M2   = 4'd6;
    localparam logic [3:0] ST_M3   = 4'd7;
    localparam logic [3:0] ST_D2S  = 4'd8;
    localparam logic [3:0] ST_D2W  = 4'd9;
    localparam logic [3:0] ST_M4   = 4'd10;
    localparam logic [3:0] ST_M5   = 4'd11;
    localparam logic [3:0] ST_D3S  = 4'd12;
    localparam logic [3:0] ST_D3W  = 4'd13;

    localparam logic [3:0] PH_LEAD = 4'd0;
    localparam logic [3:0] PH_SIGN = 4'd1;
    localparam logic [3:0] PH_INT0 = 4'd2;
    localparam logic [3:0] PH_INT  = 4'd3;
    localparam logic [3:0] PH_DOT  = 4'd4;
    localparam logic [3:0] PH_FRAC = 4'd5;
    localparam logic [3:0] PH_USP  = 4'd6;
    localparam logic [3:0] PH_U1   = 4'd7;
    localparam logic [3:0] PH_U2   = 4'd8;
    localparam logic [3:0] PH_SEP  = 4'd9;
    localparam logic [3:0] PH_DONE = 4'd10;

    localparam logic [1:0] POST_KEEP    = 2'd0;
    localparam logic [1:0] POST_CONSUME = 2'd1;
    localparam logic [1:0] POST_SWAP    = 2'd2;

    logic [3:0]                    r_state;
    logic [3:0]                    r_phase;
    logic [psd_pkg::SYM_W-1:0]     r_sym;
    logic [psd_pkg::SYM_W-1:0]     r_nxt;
    logic                          r_nxt_v;
    logic                          r_last;
    logic                          r_end_fed;
    logic                          r_dim;
    logic                          r_neg;
    logic [psd_pkg::WHOLE_W-1:0]   r_whole;
    logic [psd_pkg::FRAC_W-1:0]    r_fn;
    logic [psd_pkg::FRAC_W-1:0]    r_fd;
    logic [7:0]                    r_ufc;
    logic [31:0]                   r_res1;
    logic [31:0]                   r_res2;
    logic                          r_ovf;
    logic                          r_def;
    logic [1:0]                    r_post;
    logic [psd_pkg::SC_W-1:0]      r_sc;
    logic [psd_pkg::SC_W-1:0]      r_q;
    logic [psd_pkg::FRAC_W-1:0]    r_rm;
    logic [63:0]                   r_prod;
    logic [psd_pkg::ACC_W-1:0]     r_acc;
    logic [15:0]                   r_dpi;
    logic [7:0]                    r_sh;
    logic                          r_ovalid;
    logic [31:0]                   r_owidth;
    logic [31:0]                   r_oheight;
    logic                          r_oovf;
    logic                          r_odef;

    logic [7:0]                    sym_ch;
    logic                          sym_end;
    logic                          is_dig;
    logic [3:0]                    dig;
    psd_pkg::t_unit_hit            uhit;
    logic                          unit_ok;
    logic                          adv_end;
    logic [3:0]                    adv_state;
    logic [psd_pkg::SYM_W-1:0]     adv_sym;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic [63:0]                   prod_full;
    logic [psd_pkg::ACC_W:0]       sum;
    logic [7:0]                    sh_eff;
    logic [31:0]                   dres;
    psd_pkg::t_div_req             div_req;
    psd_pkg::t_div_rsp             div_rsp;

    psd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        sym_ch  = r_sym[7:0];
        sym_end = r_sym[8];
        is_dig  = !sym_end && sym_ch >= psd_pkg::CH_ZERO && sym_ch <= psd_pkg::CH_NINE;
        dig     = sym_ch[3:0];
        uhit    = psd_pkg::unit_lookup(r_ufc, sym_ch);
        unit_ok = uhit.hit && !sym_end;

        // Next symbol after the current one is used up
        adv_end   = !r_nxt_v && r_last && !r_end_fed;
        adv_sym   = r_nxt_v ? r_nxt : psd_pkg::SYM_END;
        if (r_nxt_v || adv_end) begin
            adv_state = ST_STEP;
        end else if (r_last) begin
            adv_state = ST_EMIT;
        end else begin
            adv_state = ST_IDLE;
        end

        sh_eff = (r_sh == 8'd0) ? 8'd1 : r_sh;

        unique case (r_state)
            ST_M1: begin
                mul_a = 32'(r_whole);
                mul_b = 32'(r_sc);
            end
            ST_M2: begin
                mul_a = 32'(r_fn);
                mul_b = 32'(r_q);
            end
            ST_M3: begin
                mul_a = 32'(r_rm);
                mul_b = 32'(r_fn);
            end
            ST_M4: begin
                mul_a = 32'(r_acc[30:0]);
                mul_b = 32'(r_dpi);
            end
            ST_M5: begin
                mul_a = 32'(sh_eff);
                mul_b = 32'(psd_pkg::INCH_SP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_full = mul_a * mul_b;

        sum = {1'b0, r_acc} + {1'b0, r_prod[psd_pkg::ACC_W-1:0]};

        div_req.start = (r_state == ST_D1S) || (r_state == ST_D2S) || (r_state == ST_D3S);
        unique case (r_state)
            ST_D1S: begin
                div_req.dividend = psd_pkg::DIV_DW'(r_sc);
                div_req.divisor  = psd_pkg::DIV_SW'(r_fd);
            end
            ST_D2S: begin
                div_req.dividend = psd_pkg::DIV_DW'({r_prod[29:0], 1'b0})
                                 + psd_pkg::DIV_DW'(r_fd);
                div_req.divisor  = psd_pkg::DIV_SW'({r_fd, 1'b0});
            end
            default: begin
                div_req.dividend = r_acc[psd_pkg::DIV_DW-1:0];
                div_req.divisor  = r_prod[psd_pkg::DIV_SW-1:0];
            end
        endcase

        dres = r_neg ? (32'd0 - div_rsp.quot[31:0]) : div_rsp.quot[31:0];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpi <= 16'd300;
            r_sh  <= 8'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == psd_pkg::CFG_DPI) begin
                r_dpi <= i_cfg_data;
            end else if (i_cfg_index == psd_pkg::CFG_SHRINK) begin
                r_sh <= i_cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_LEAD;
            r_nxt_v   <= 1'b0;
            r_last    <= 1'b0;
            r_end_fed <= 1'b0;
            r_dim     <= 1'b0;
            r_neg     <= 1'b0;
            r_whole   <= '0;
            r_fn      <= '0;
            r_fd      <= 15'd1;
            r_ufc     <= '0;
            r_res1    <= '0;
            r_res2    <= '0;
            r_ovf     <= 1'b0;
            r_def     <= 1'b0;
            r_post    <= POST_KEEP;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != ST_EMIT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_sym   <= {1'b0, i_ch};
                        r_last  <= i_last;
                        r_nxt_v <= 1'b0;
                        r_state <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    unique case (r_phase)
                        PH_LEAD: begin
                            if (!sym_end && sym_ch == psd_pkg::CH_SPACE) begin
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end else begin
                                r_phase <= PH_SIGN;
                            end
                        end
                        PH_SEP: begin
                            if (!sym_end && (sym_ch == psd_pkg::CH_SPACE ||
                                             sym_ch == psd_pkg::CH_COMMA)) begin
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end else begin
                                r_phase <= PH_SIGN;
                            end
                        end
                        PH_SIGN: begin
                            r_phase <= PH_INT0;
                            if (!sym_end && sym_ch == psd_pkg::CH_MINUS) begin
                                r_neg     <= 1'b1;
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end
                        end
                        PH_INT0: begin
                            if (is_dig) begin
                                r_whole   <= psd_pkg::WHOLE_W'(dig);
                                r_phase   <= PH_INT;
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end else begin
                                // no number given: assume ten
                                r_whole <= psd_pkg::WHOLE_W'(10);
                                r_def   <= 1'b1;
                                r_phase <= PH_DOT;
                            end
                        end
                        PH_INT: begin
                            if (is_dig) begin
                                if (r_whole > psd_pkg::WHOLE_LIMIT) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_whole <= psd_pkg::WHOLE_W'(r_whole * 4'd10)
                                             + psd_pkg::WHOLE_W'(dig);
                                end
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end else begin
                                r_phase <= PH_DOT;
                            end
                        end
                        PH_DOT: begin
                            if (!sym_end && sym_ch == psd_pkg::CH_DOT) begin
                                r_phase   <= PH_FRAC;
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end else begin
                                r_phase <= PH_USP;
                            end
                        end
                        PH_FRAC: begin
                            if (is_dig) begin
                                if (r_fd <= 15'd1000) begin
                                    r_fd <= psd_pkg::FRAC_W'(r_fd * 4'd10);
                                    r_fn <= psd_pkg::FRAC_W'(r_fn * 4'd10)
                                          + psd_pkg::FRAC_W'(dig);
                                end else if (r_fd == 15'd10000) begin
                                    // half-digit step
                                    r_fd <= 15'd20000;
                                    r_fn <= {r_fn[psd_pkg::FRAC_W-2:0], 1'b0}
                                          + psd_pkg::FRAC_W'(dig >= 4'd5);
                                end
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end else begin
                                r_phase <= PH_USP;
                            end
                        end
                        PH_USP: begin
                            if (!sym_end && sym_ch == psd_pkg::CH_SPACE) begin
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end else begin
                                r_phase <= PH_U1;
                            end
                        end
                        PH_U1: begin
                            if (sym_end) begin
                                r_def   <= 1'b1;
                                r_sc    <= psd_pkg::INCH_SP;
                                r_post  <= POST_KEEP;
                                r_state <= ST_D1S;
                            end else begin
                                r_ufc     <= sym_ch;
                                r_phase   <= PH_U2;
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end
                        end
                        PH_U2: begin
                            if (unit_ok) begin
                                r_sc   <= uhit.sc;
                                r_post <= POST_CONSUME;
                            end else begin
                                // unknown unit: inches, then re-read both characters
                                r_def  <= 1'b1;
                                r_sc   <= psd_pkg::INCH_SP;
                                r_post <= POST_SWAP;
                            end
                            r_state <= ST_D1S;
                        end
                        default: begin
                            r_state   <= adv_state;
                            r_sym     <= adv_sym;
                            r_nxt_v   <= 1'b0;
                            r_end_fed <= r_end_fed | adv_end;
                        end
                    endcase
                end
                ST_D1S: r_state <= ST_D1W;
                ST_D1W: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quot[psd_pkg::SC_W-1:0];
                        r_rm    <= div_rsp.rem[psd_pkg::FRAC_W-1:0];
                        r_state <= ST_M1;
                    end
                end
                ST_M1: begin
                    r_prod  <= prod_full;
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_acc   <= r_prod[psd_pkg::ACC_W-1:0];
                    r_prod  <= prod_full;
                    r_state <= ST_M3;
                end
                ST_M3: begin
                    if (sum > (psd_pkg::ACC_W+1)'(psd_pkg::SCALED_MAX)) begin
                        r_ovf <= 1'b1;
                        r_acc <= psd_pkg::SCALED_MAX;
                    end else begin
                        r_acc <= sum[psd_pkg::ACC_W-1:0];
                    end
                    r_prod  <= prod_full;
                    r_state <= ST_D2S;
                end
                ST_D2S: r_state <= ST_D2W;
                ST_D2W: begin
                    if (div_rsp.done) begin
                        r_acc   <= r_acc + psd_pkg::ACC_W'(div_rsp.quot);
                        r_state <= ST_M4;
                    end
                end
                ST_M4: begin
                    r_prod  <= prod_full;
                    r_state <= ST_M5;
                end
                ST_M5: begin
                    r_acc   <= psd_pkg::ACC_W'(r_prod[psd_pkg::DIV_DW-1:0]);
                    r_prod  <= prod_full;
                    r_state <= ST_D3S;
                end
                ST_D3S: r_state <= ST_D3W;
                ST_D3W: begin
                    if (div_rsp.done) begin
                        if (!r_dim) begin
                            r_res1  <= dres;
                            r_dim   <= 1'b1;
                            r_phase <= PH_SEP;
                        end else begin
                            r_res2  <= dres;
                            r_phase <= PH_DONE;
                        end
                        r_neg   <= 1'b0;
                        r_whole <= '0;
                        r_fn    <= '0;
                        r_fd    <= 15'd1;
                        r_ufc   <= '0;
                        unique case (r_post)
                            POST_CONSUME: begin
                                r_state   <= adv_state;
                                r_sym     <= adv_sym;
                                r_nxt_v   <= 1'b0;
                                r_end_fed <= r_end_fed | adv_end;
                            end
                            POST_SWAP: begin
                                r_nxt   <= r_sym;
                                r_nxt_v <= 1'b1;
                                r_sym   <= {1'b0, r_ufc};
                                r_state <= ST_STEP;
                            end
                            default: r_state <= ST_STEP;
                        endcase
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_ready) begin
                        r_ovalid  <= 1'b1;
                        r_owidth  <= r_res1;
                        r_oheight <= r_res2;
                        r_oovf    <= r_ovf;
                        r_odef    <= r_def;
                        r_phase   <= PH_LEAD;
                        r_dim     <= 1'b0;
                        r_neg     <= 1'b0;
                        r_whole   <= '0;
                        r_fn      <= '0;
                        r_fd      <= 15'd1;
                        r_ufc     <= '0;
                        r_res1    <= '0;
                        r_res2    <= '0;
                        r_ovf     <= 1'b0;
                        r_def     <= 1'b0;
                        r_last    <= 1'b0;
                        r_end_fed <= 1'b0;
                        r_nxt_v   <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_width_dots    = r_owidth;
    assign o_height_dots   = r_oheight;
    assign o_overflow      = r_oovf;
    assign o_defaults_used = r_odef;

endmodule
